[hw/rtl/ptc_pkg.sv]
package ptc_pkg;

  localparam int SRC_DEPTH = 1024;
  localparam int SRC_AW    = $clog2(SRC_DEPTH);
  localparam int SRC_CW    = $clog2(SRC_DEPTH + 1);

  localparam int FRAME_MAX = 2048;
  localparam int OFF_W     = $clog2(FRAME_MAX + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
  localparam logic [15:0] ETYPE_ARP        = 16'h0806;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [5:0]  FLAGS_SYN_ONLY   = 6'h02;
  localparam logic [15:0] ARP_OP_REPLY     = 16'd2;
  localparam logic [15:0] WATCHED_PORT_RST = 16'd80;
  localparam logic [3:0]  TCP_DOFF_MIN     = 4'd5;

  localparam int OFF_ETYPE_HI = 12;
  localparam int OFF_ETYPE_LO = 13;
  localparam int OFF_IHL      = 14;
  localparam int OFF_ARPOP_HI = 20;
  localparam int OFF_ARPOP_LO = 21;
  localparam int OFF_PROTO    = 23;
  localparam int OFF_SRC_LO   = 26;
  localparam int OFF_SRC_HI   = 29;
  localparam int ETH_LEN      = 14;
  localparam int TCP_PORT_HI  = 2;
  localparam int TCP_PORT_LO  = 3;
  localparam int TCP_DOFF     = 12;
  localparam int TCP_FLAGS    = 13;

  localparam int PAT_MAX = 16;
  localparam int PAT_W   = $clog2(PAT_MAX + 1);
  localparam int GET_LEN = 3;
  localparam int GET_W   = $clog2(GET_LEN + 1);
  localparam int HOST_LEN = 16;

  typedef logic [0:PAT_MAX-1][7:0] pat_t;
  typedef logic [0:PAT_MAX][0:PAT_MAX] border_t;

  localparam pat_t PAT_GET = 128'h47455400_00000000_00000000_00000000;
  localparam pat_t PAT_HOST_A = 128'h7777772E_676F6F67_6C652E63_6F2E756B;
  localparam pat_t PAT_HOST_B = 128'h7777772E_66616365_626F6F6B_2E636F6D;

  // bit [p][j]: the first j pattern bytes equal the j bytes that end at position p
  function automatic border_t border_mat(input pat_t pat);
    border_t m;
    for (int p = 0; p <= PAT_MAX; p++) begin
      for (int j = 0; j <= PAT_MAX; j++) begin
        m[p][j] = (j <= p);
        for (int i = 0; i < PAT_MAX; i++) begin
          if (i < j && j <= p) begin
            if (pat[i] != pat[p - j + i]) m[p][j] = 1'b0;
          end
        end
      end
    end
    return m;
  endfunction

  localparam border_t BORDER_GET    = border_mat(PAT_GET);
  localparam border_t BORDER_HOST_A = border_mat(PAT_HOST_A);
  localparam border_t BORDER_HOST_B = border_mat(PAT_HOST_B);

  // longest pattern prefix that ends on this byte
  function automatic logic [PAT_W-1:0] match_step(input pat_t pat, input int len,
                                                  input border_t bm,
                                                  input logic [PAT_W-1:0] pos,
                                                  input logic [7:0] c);
    logic [PAT_W-1:0] best;
    best = '0;
    if (int'(pos) >= len) begin
      best = PAT_W'(len);
    end else begin
      for (int k = 1; k <= PAT_MAX; k++) begin
        if (k <= len && (k - 1) <= int'(pos) && pat[k-1] == c && bm[pos][k-1])
          best = PAT_W'(k);
      end
    end
    return best;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  typedef struct packed {
    logic        syn;
    logic        arp;
    logic        hit_a;
    logic        hit_b;
    logic [31:0] src_addr;
  } frame_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DECIDE
  } back_state_t;

endpackage

[hw/rtl/packet_threat_classifier_core.sv]
// Ethernet frame classifier. Frame bytes stream in one per cycle; the parser and
// payload scanner keep up with line rate and only stall when the four-entry frame
// queue is full. One result comes out per frame, after its last byte has been taken.
// A SYN-only frame makes the back end search the source table (1024 x 32 memory)
// one entry at a time, read then compare, until a hit or the last stored entry;
// other frames, and SYN-only frames while the table is empty, skip the search.
// The watched port register resets to 80 and is written through the cfg channel.
module packet_threat_classifier_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_syn_only,
  output logic        out_new_source,
  output logic        out_source_table_full,
  output logic        out_arp_reply,
  output logic        out_host_a_hit,
  output logic        out_host_b_hit,
  output logic [31:0] out_syn_total,
  output logic [10:0] out_distinct_sources,
  output logic [31:0] out_arp_reply_total,
  output logic [31:0] out_host_a_total,
  output logic [31:0] out_host_b_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_watched_port
);

  logic [15:0]     watched_port_r;
  logic            q_full, q_push, q_pop, q_valid;
  ptc_pkg::frame_t q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) watched_port_r <= ptc_pkg::WATCHED_PORT_RST;
    else if (cfg_valid && cfg_ready) watched_port_r <= cfg_watched_port;
  end

  ptc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .watched_port (watched_port_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  ptc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  ptc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_data                (q_head),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_syn_only          (out_syn_only),
    .out_new_source        (out_new_source),
    .out_source_table_full (out_source_table_full),
    .out_arp_reply         (out_arp_reply),
    .out_host_a_hit        (out_host_a_hit),
    .out_host_b_hit        (out_host_b_hit),
    .out_syn_total         (out_syn_total),
    .out_distinct_sources  (out_distinct_sources),
    .out_arp_reply_total   (out_arp_reply_total),
    .out_host_a_total      (out_host_a_total),
    .out_host_b_total      (out_host_b_total)
  );

endmodule

[hw/rtl/ptc_queue.sv]
module ptc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ptc_pkg::frame_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ptc_pkg::frame_t head_data
);

  ptc_pkg::frame_t                   mem_r [ptc_pkg::QUEUE_DEPTH];
  logic [ptc_pkg::QPTR_W-1:0]        wptr_r, rptr_r;
  logic [ptc_pkg::QCNT_W-1:0]        cnt_r;

  assign full       = (cnt_r == ptc_pkg::QCNT_W'(ptc_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[hw/rtl/ptc_front.sv]
module ptc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  input  logic [15:0]     watched_port,
  input  logic            q_full,
  output logic            q_push,
  output ptc_pkg::frame_t q_data
);

  logic [ptc_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [15:0] port_r, port_nxt;
  logic [3:0]  doff_r, doff_nxt;
  logic [15:0] arpop_r, arpop_nxt;
  logic        stop_r, stop_nxt;
  logic [ptc_pkg::GET_W-1:0] gpos_r, gpos_nxt;
  logic [ptc_pkg::PAT_W-1:0] apos_r, apos_nxt;
  logic [ptc_pkg::PAT_W-1:0] bpos_r, bpos_nxt;
  logic [2:0]  found_r, found_nxt;

  logic                      beat, take, is_tcp;
  logic [3:0]                dw;
  logic [ptc_pkg::OFF_W-1:0] tcp_pos, pay_pos;
  logic [ptc_pkg::PAT_W-1:0] gstep;

  assign in_stall = q_full;
  assign beat     = in_valid && !in_stall;
  assign take     = beat && (off_r < ptc_pkg::OFF_W'(ptc_pkg::FRAME_MAX));

  assign dw      = (doff_r < ptc_pkg::TCP_DOFF_MIN) ? ptc_pkg::TCP_DOFF_MIN : doff_r;
  assign tcp_pos = ptc_pkg::OFF_W'(ptc_pkg::ETH_LEN) + ptc_pkg::OFF_W'({ihl_r, 2'b00});
  assign pay_pos = tcp_pos + ptc_pkg::OFF_W'({dw, 2'b00});

  always_comb begin
    off_nxt   = off_r;
    etype_nxt = etype_r;
    ihl_nxt   = ihl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    flags_nxt = flags_r;
    port_nxt  = port_r;
    doff_nxt  = doff_r;
    arpop_nxt = arpop_r;
    stop_nxt  = stop_r;
    gpos_nxt  = gpos_r;
    apos_nxt  = apos_r;
    bpos_nxt  = bpos_r;
    found_nxt = found_r;
    gstep     = '0;
    if (take) begin
      off_nxt = off_r + 1'b1;
      if (off_r == ptc_pkg::OFF_W'(ptc_pkg::OFF_ETYPE_HI)) etype_nxt[15:8] = in_data_byte;
      if (off_r == ptc_pkg::OFF_W'(ptc_pkg::OFF_ETYPE_LO)) etype_nxt[7:0]  = in_data_byte;
      if (off_r == ptc_pkg::OFF_W'(ptc_pkg::OFF_IHL))      ihl_nxt = in_data_byte[3:0];
      if (off_r == ptc_pkg::OFF_W'(ptc_pkg::OFF_ARPOP_HI)) arpop_nxt[15:8] = in_data_byte;
      if (off_r == ptc_pkg::OFF_W'(ptc_pkg::OFF_ARPOP_LO)) arpop_nxt[7:0]  = in_data_byte;
      if (off_r == ptc_pkg::OFF_W'(ptc_pkg::OFF_PROTO))    proto_nxt = in_data_byte;
      if (off_r >= ptc_pkg::OFF_W'(ptc_pkg::OFF_SRC_LO) &&
          off_r <= ptc_pkg::OFF_W'(ptc_pkg::OFF_SRC_HI))
        src_nxt = {src_r[23:0], in_data_byte};
      if (off_r == tcp_pos + ptc_pkg::OFF_W'(ptc_pkg::TCP_PORT_HI))
        port_nxt[15:8] = in_data_byte;
      if (off_r == tcp_pos + ptc_pkg::OFF_W'(ptc_pkg::TCP_PORT_LO))
        port_nxt[7:0] = in_data_byte;
      if (off_r == tcp_pos + ptc_pkg::OFF_W'(ptc_pkg::TCP_DOFF))
        doff_nxt = in_data_byte[7:4];
      if (off_r == tcp_pos + ptc_pkg::OFF_W'(ptc_pkg::TCP_FLAGS))
        flags_nxt = in_data_byte[5:0];
      if (off_r >= pay_pos && !stop_r) begin
        if (in_data_byte == 8'd0) begin
          stop_nxt = 1'b1;
        end else begin
          gstep    = ptc_pkg::match_step(ptc_pkg::PAT_GET, ptc_pkg::GET_LEN,
                                         ptc_pkg::BORDER_GET,
                                         ptc_pkg::PAT_W'(gpos_r), in_data_byte);
          gpos_nxt = gstep[ptc_pkg::GET_W-1:0];
          apos_nxt = ptc_pkg::match_step(ptc_pkg::PAT_HOST_A, ptc_pkg::HOST_LEN,
                                         ptc_pkg::BORDER_HOST_A, apos_r, in_data_byte);
          bpos_nxt = ptc_pkg::match_step(ptc_pkg::PAT_HOST_B, ptc_pkg::HOST_LEN,
                                         ptc_pkg::BORDER_HOST_B, bpos_r, in_data_byte);
          if (gstep == ptc_pkg::PAT_W'(ptc_pkg::GET_LEN))     found_nxt[0] = 1'b1;
          if (apos_nxt == ptc_pkg::PAT_W'(ptc_pkg::HOST_LEN)) found_nxt[1] = 1'b1;
          if (bpos_nxt == ptc_pkg::PAT_W'(ptc_pkg::HOST_LEN)) found_nxt[2] = 1'b1;
        end
      end
    end
  end

  // frame summary is built from this beat's updated fields
  assign is_tcp = (etype_nxt == ptc_pkg::ETYPE_IPV4) && (proto_nxt == ptc_pkg::PROTO_TCP);
  assign q_push = beat && in_last_byte;

  always_comb begin
    q_data          = '0;
    q_data.syn      = is_tcp && (flags_nxt == ptc_pkg::FLAGS_SYN_ONLY);
    q_data.arp      = (etype_nxt == ptc_pkg::ETYPE_ARP) && (arpop_nxt == ptc_pkg::ARP_OP_REPLY);
    q_data.hit_a    = is_tcp && (port_nxt == watched_port) && found_nxt[0] && found_nxt[1];
    q_data.hit_b    = is_tcp && (port_nxt == watched_port) && found_nxt[0] &&
                      !found_nxt[1] && found_nxt[2];
    q_data.src_addr = src_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      off_r   <= '0;
      etype_r <= '0;
      ihl_r   <= '0;
      proto_r <= '0;
      src_r   <= '0;
      flags_r <= '0;
      port_r  <= '0;
      doff_r  <= '0;
      arpop_r <= '0;
      stop_r  <= 1'b0;
      gpos_r  <= '0;
      apos_r  <= '0;
      bpos_r  <= '0;
      found_r <= '0;
    end else begin
      off_r   <= off_nxt;
      etype_r <= etype_nxt;
      ihl_r   <= ihl_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      flags_r <= flags_nxt;
      port_r  <= port_nxt;
      doff_r  <= doff_nxt;
      arpop_r <= arpop_nxt;
      stop_r  <= stop_nxt;
      gpos_r  <= gpos_nxt;
      apos_r  <= apos_nxt;
      bpos_r  <= bpos_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

[hw/rtl/ptc_back.sv]
module ptc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  ptc_pkg::frame_t            q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_syn_only,
  output logic                       out_new_source,
  output logic                       out_source_table_full,
  output logic                       out_arp_reply,
  output logic                       out_host_a_hit,
  output logic                       out_host_b_hit,
  output logic [31:0]                out_syn_total,
  output logic [ptc_pkg::SRC_CW-1:0] out_distinct_sources,
  output logic [31:0]                out_arp_reply_total,
  output logic [31:0]                out_host_a_total,
  output logic [31:0]                out_host_b_total
);

  ptc_pkg::back_state_t state_r, state_nxt;
  ptc_pkg::frame_t      item_r, item_nxt;
  logic [ptc_pkg::SRC_AW-1:0] idx_r, idx_nxt;
  logic [ptc_pkg::SRC_CW-1:0] count_r, count_nxt;
  logic                       seen_r, seen_nxt;
  logic [31:0] syn_tot_r, syn_tot_nxt, arp_tot_r, arp_tot_nxt;
  logic [31:0] a_tot_r, a_tot_nxt, b_tot_r, b_tot_nxt;
  logic [31:0] rd_data_r;
  logic [31:0] table_r [ptc_pkg::SRC_DEPTH];

  logic out_valid_r, out_valid_nxt;
  logic o_syn_r, o_new_r, o_full_r, o_arp_r, o_a_r, o_b_r;
  logic o_syn_nxt, o_new_nxt, o_full_nxt, o_arp_nxt, o_a_nxt, o_b_nxt;
  logic [31:0] o_syn_tot_r, o_arp_tot_r, o_a_tot_r, o_b_tot_r;
  logic [ptc_pkg::SRC_CW-1:0] o_cnt_r;

  logic can_out, hit, last_entry, has_room, fresh, full_hit, mem_we, out_load;

  assign can_out    = !out_valid_r || !out_stall;
  assign hit        = (rd_data_r == item_r.src_addr);
  assign last_entry = (ptc_pkg::SRC_CW'(idx_r) + 1'b1) == count_r;
  assign has_room   = count_r < ptc_pkg::SRC_CW'(ptc_pkg::SRC_DEPTH);
  assign fresh      = item_r.syn && !seen_r && has_room;
  assign full_hit   = item_r.syn && !seen_r && !has_room;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptc_pkg::ST_IDLE: begin
        if (q_valid)
          state_nxt = (q_data.syn && count_r != '0) ? ptc_pkg::ST_READ : ptc_pkg::ST_DECIDE;
      end
      ptc_pkg::ST_READ:   state_nxt = ptc_pkg::ST_CMP;
      ptc_pkg::ST_CMP:    state_nxt = (hit || last_entry) ? ptc_pkg::ST_DECIDE : ptc_pkg::ST_READ;
      ptc_pkg::ST_DECIDE: if (can_out) state_nxt = ptc_pkg::ST_IDLE;
      default:            state_nxt = ptc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ptc_pkg::ST_IDLE:   q_pop = q_valid;
      ptc_pkg::ST_DECIDE: begin
        out_load = can_out;
        mem_we   = can_out && fresh;
      end
      default: ;
    endcase
  end

  always_comb begin
    item_nxt    = item_r;
    idx_nxt     = idx_r;
    seen_nxt    = seen_r;
    count_nxt   = count_r;
    syn_tot_nxt = syn_tot_r;
    arp_tot_nxt = arp_tot_r;
    a_tot_nxt   = a_tot_r;
    b_tot_nxt   = b_tot_r;
    o_syn_nxt   = item_r.syn;
    o_new_nxt   = fresh;
    o_full_nxt  = full_hit;
    o_arp_nxt   = item_r.arp;
    o_a_nxt     = item_r.hit_a;
    o_b_nxt     = item_r.hit_b;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      item_nxt = q_data;
      idx_nxt  = '0;
      seen_nxt = 1'b0;
    end
    if (state_r == ptc_pkg::ST_CMP) begin
      if (hit) seen_nxt = 1'b1;
      else if (!last_entry) idx_nxt = idx_r + 1'b1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (fresh)        count_nxt   = count_r + 1'b1;
      if (item_r.syn)   syn_tot_nxt = ptc_pkg::sat_inc(syn_tot_r);
      if (item_r.arp)   arp_tot_nxt = ptc_pkg::sat_inc(arp_tot_r);
      if (item_r.hit_a) a_tot_nxt   = ptc_pkg::sat_inc(a_tot_r);
      if (item_r.hit_b) b_tot_nxt   = ptc_pkg::sat_inc(b_tot_r);
    end
  end

  // source table, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) table_r[count_r[ptc_pkg::SRC_AW-1:0]] <= item_r.src_addr;
    rd_data_r <= table_r[idx_r];
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    idx_r  <= idx_nxt;
    seen_r <= seen_nxt;
    if (out_load) begin
      o_syn_r     <= o_syn_nxt;
      o_new_r     <= o_new_nxt;
      o_full_r    <= o_full_nxt;
      o_arp_r     <= o_arp_nxt;
      o_a_r       <= o_a_nxt;
      o_b_r       <= o_b_nxt;
      o_syn_tot_r <= syn_tot_nxt;
      o_arp_tot_r <= arp_tot_nxt;
      o_a_tot_r   <= a_tot_nxt;
      o_b_tot_r   <= b_tot_nxt;
      o_cnt_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptc_pkg::ST_IDLE;
      count_r     <= '0;
      syn_tot_r   <= '0;
      arp_tot_r   <= '0;
      a_tot_r     <= '0;
      b_tot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      syn_tot_r   <= syn_tot_nxt;
      arp_tot_r   <= arp_tot_nxt;
      a_tot_r     <= a_tot_nxt;
      b_tot_r     <= b_tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_syn_only          = o_syn_r;
  assign out_new_source        = o_new_r;
  assign out_source_table_full = o_full_r;
  assign out_arp_reply         = o_arp_r;
  assign out_host_a_hit        = o_a_r;
  assign out_host_b_hit        = o_b_r;
  assign out_syn_total         = o_syn_tot_r;
  assign out_distinct_sources  = o_cnt_r;
  assign out_arp_reply_total   = o_arp_tot_r;
  assign out_host_a_total      = o_a_tot_r;
  assign out_host_b_total      = o_b_tot_r;

endmodule

[sim/ptc_frame_checker.sv]
module ptc_frame_checker
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_syn_only,
  input  logic        out_new_source,
  input  logic        out_source_table_full,
  input  logic        out_arp_reply,
  input  logic        out_host_a_hit,
  input  logic        out_host_b_hit,
  input  logic [31:0] out_syn_total,
  input  logic [10:0] out_distinct_sources,
  input  logic [31:0] out_arp_reply_total,
  input  logic [31:0] out_host_a_total,
  input  logic [31:0] out_host_b_total,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_watched_port,
  output int          mismatches,
  output int          outstanding,
  output int          frames_done
);

  typedef struct {
    logic        syn;
    logic        fresh;
    logic        full;
    logic        arp;
    logic        hit_a;
    logic        hit_b;
    logic [31:0] syn_total;
    logic [10:0] sources;
    logic [31:0] arp_total;
    logic [31:0] a_total;
    logic [31:0] b_total;
  } frame_verdict_t;

  frame_verdict_t verdicts[$];

  logic [15:0] port_cfg;
  int          offs;
  logic [15:0] etype, arpop, dport;
  logic [3:0]  ihl, doff;
  logic [7:0]  proto;
  logic [31:0] src;
  logic [5:0]  flags;
  logic        stopped, got_get, got_a, got_b;
  int          get_pos, a_pos, b_pos;
  logic [31:0] src_table[$];
  logic [31:0] syn_cnt, arp_cnt, a_cnt, b_cnt;

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // longest prefix of the pattern that ends with this byte
  function automatic int next_pos(input pat_t p, input int len, input int pos,
                                  input logic [7:0] c);
    bit ok;
    if (pos >= len) return len;
    if (p[pos] == c) return pos + 1;
    for (int k = pos; k >= 1; k--) begin
      ok = (p[k-1] == c);
      for (int i = 0; i < k - 1; i++)
        if (p[i] != p[pos - k + 1 + i]) ok = 0;
      if (ok) return k;
    end
    return 0;
  endfunction

  task automatic clear_frame();
    offs = 0; etype = '0; arpop = '0; dport = '0; ihl = '0; doff = '0;
    proto = '0; src = '0; flags = '0; stopped = 0;
    got_get = 0; got_a = 0; got_b = 0; get_pos = 0; a_pos = 0; b_pos = 0;
  endtask

  task automatic reset_model();
    clear_frame();
    port_cfg = WATCHED_PORT_RST;
    src_table = {};
    verdicts = {};
    syn_cnt = '0; arp_cnt = '0; a_cnt = '0; b_cnt = '0;
    mismatches = 0;
    frames_done = 0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int tcp, dw;
    bit is_tcp, seen;
    frame_verdict_t v;
    if (offs < FRAME_MAX) begin
      if (offs == 12) etype[15:8] = b;
      if (offs == 13) etype[7:0] = b;
      if (offs == 14) ihl = b[3:0];
      if (offs == 20) arpop[15:8] = b;
      if (offs == 21) arpop[7:0] = b;
      if (offs == 23) proto = b;
      if (offs >= 26 && offs <= 29) src = {src[23:0], b};
      tcp = 14 + int'(ihl) * 4;
      if (offs == tcp + 2) dport[15:8] = b;
      if (offs == tcp + 3) dport[7:0] = b;
      if (offs == tcp + 12) doff = b[7:4];
      if (offs == tcp + 13) flags = b[5:0];
      // payload never starts before the flags byte
      dw = (doff < 5) ? 5 : int'(doff);
      if (offs >= tcp + dw * 4 && !stopped) begin
        if (b == 8'd0) begin
          stopped = 1;
        end else begin
          get_pos = next_pos(PAT_GET, GET_LEN, get_pos, b);
          a_pos = next_pos(PAT_HOST_A, HOST_LEN, a_pos, b);
          b_pos = next_pos(PAT_HOST_B, HOST_LEN, b_pos, b);
          if (get_pos == GET_LEN) got_get = 1;
          if (a_pos == HOST_LEN) got_a = 1;
          if (b_pos == HOST_LEN) got_b = 1;
        end
      end
      offs++;
    end
    if (!last) return;

    v = '{default: '0};
    is_tcp = (etype == ETYPE_IPV4) && (proto == PROTO_TCP);
    if (is_tcp && flags == FLAGS_SYN_ONLY) begin
      v.syn = 1;
      syn_cnt = bump(syn_cnt);
      seen = 0;
      foreach (src_table[i]) if (src_table[i] == src) seen = 1;
      if (!seen) begin
        if (src_table.size() < SRC_DEPTH) begin
          src_table.push_back(src);
          v.fresh = 1;
        end else begin
          v.full = 1;
        end
      end
    end
    if (is_tcp && dport == port_cfg && got_get) begin
      if (got_a) begin
        v.hit_a = 1;
        a_cnt = bump(a_cnt);
      end else if (got_b) begin
        v.hit_b = 1;
        b_cnt = bump(b_cnt);
      end
    end
    if (etype == ETYPE_ARP && arpop == ARP_OP_REPLY) begin
      v.arp = 1;
      arp_cnt = bump(arp_cnt);
    end
    v.syn_total = syn_cnt;
    v.sources = 11'(src_table.size());
    v.arp_total = arp_cnt;
    v.a_total = a_cnt;
    v.b_total = b_cnt;
    verdicts.push_back(v);
    clear_frame();
  endtask

  task automatic chk(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endtask

  task automatic compare_frame();
    frame_verdict_t v;
    if (verdicts.size() == 0) begin
      $error("result beat with no frame outstanding");
      mismatches++;
      return;
    end
    v = verdicts.pop_front();
    frames_done++;
    chk("syn_only", v.syn, out_syn_only);
    chk("new_source", v.fresh, out_new_source);
    chk("source_table_full", v.full, out_source_table_full);
    chk("arp_reply", v.arp, out_arp_reply);
    chk("host_a_hit", v.hit_a, out_host_a_hit);
    chk("host_b_hit", v.hit_b, out_host_b_hit);
    chk("syn_total", v.syn_total, out_syn_total);
    chk("distinct_sources", v.sources, out_distinct_sources);
    chk("arp_reply_total", v.arp_total, out_arp_reply_total);
    chk("host_a_total", v.a_total, out_host_a_total);
    chk("host_b_total", v.b_total, out_host_b_total);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) port_cfg = cfg_watched_port;
      if (in_valid && !in_stall) absorb_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) compare_frame();
    end
    outstanding <= verdicts.size();
  end

endmodule

[sim/testbench.sv]
module testbench;
  import ptc_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_syn_only, out_new_source, out_source_table_full, out_arp_reply;
  logic        out_host_a_hit, out_host_b_hit;
  logic [31:0] out_syn_total, out_arp_reply_total, out_host_a_total, out_host_b_total;
  logic [10:0] out_distinct_sources;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_watched_port = '0;

  int mismatches, outstanding, frames_done;
  int bytes_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int port_settings = 0;
  logic [15:0] cur_port = WATCHED_PORT_RST;
  logic [7:0] frm[$];
  logic [7:0] payload[$];
  logic [31:0] src_pool[16];

  packet_threat_classifier_core uut (.*);

  ptc_frame_checker checker_i (.*);

  initial forever #1 clk = ~clk;

  // no beat on any channel for too long means the block has hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("timeout: no beat for %0d cycles", idle_cycles);
      $display("packet_threat_classifier_core regression: fail");
      $finish;
    end
  end

  // result side: one long hold at the start so the frame queue fills, then mixed patterns
  initial begin
    int mode, len;
    @(posedge rst_n);
    @(negedge clk);
    out_stall <= 1;
    repeat (400) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 12);
      len = $urandom_range(50, 200);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0, 1, 2: out_stall <= 0;
          3, 4:    out_stall <= ($urandom_range(0, 2) == 0);
          5, 6:    out_stall <= (i % 4 == 3);
          7, 8:    out_stall <= ($urandom_range(0, 3) != 0);
          9:       out_stall <= (i < 150);
          default: out_stall <= $urandom_range(0, 1);
        endcase
        @(negedge clk);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frm[i]) put_byte(frm[i], i == frm.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    do @(negedge clk); while (outstanding != 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_port(input logic [15:0] p);
    cfg_valid <= 1;
    cfg_watched_port <= p;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    cur_port = p;
    port_settings++;
  endtask

  task automatic add_pat(input pat_t p, input int n);
    for (int i = 0; i < n; i++) payload.push_back(p[i]);
  endtask

  task automatic build_tcp(input int ihl, input int doff, input logic [15:0] port,
                           input logic [7:0] flags, input logic [31:0] src);
    int tcp, hlen;
    tcp = 14 + ihl * 4;
    hlen = tcp + ((doff < 5) ? 5 : doff) * 4;
    frm = {};
    for (int i = 0; i < hlen; i++) frm.push_back(8'($urandom_range(0, 255)));
    frm[12] = ETYPE_IPV4[15:8];
    frm[13] = ETYPE_IPV4[7:0];
    frm[14] = {4'h4, 4'(ihl)};
    frm[23] = PROTO_TCP;
    for (int i = 0; i < 4; i++) frm[26 + i] = src[31 - 8*i -: 8];
    frm[tcp + 2] = port[15:8];
    frm[tcp + 3] = port[7:0];
    frm[tcp + 12] = {4'(doff), 4'($urandom_range(0, 15))};
    frm[tcp + 13] = flags;
    foreach (payload[i]) frm.push_back(payload[i]);
  endtask

  task automatic build_arp(input logic [15:0] op);
    frm = {};
    repeat ($urandom_range(22, 60)) frm.push_back(8'($urandom_range(0, 255)));
    frm[12] = ETYPE_ARP[15:8];
    frm[13] = ETYPE_ARP[7:0];
    frm[20] = op[15:8];
    frm[21] = op[7:0];
  endtask

  task automatic add_piece();
    case ($urandom_range(0, 11))
      0, 1: add_pat(PAT_GET, GET_LEN);
      2:    add_pat(PAT_HOST_A, HOST_LEN);
      3:    add_pat(PAT_HOST_B, HOST_LEN);
      4:    add_pat($urandom_range(0, 1) ? PAT_HOST_A : PAT_HOST_B, $urandom_range(1, 15));
      5:    add_pat(PAT_GET, $urandom_range(1, 2));
      6:    repeat ($urandom_range(1, 4)) payload.push_back(PAT_HOST_A[0]);
      7:    payload.push_back(8'd0);
      8:    payload.push_back(8'($urandom_range(0, 255)));
      default: repeat ($urandom_range(1, 4)) payload.push_back(8'($urandom_range(32, 126)));
    endcase
  endtask

  task automatic random_frame();
    int kind, ihl, doff;
    logic [15:0] port;
    logic [7:0] flags;
    logic [31:0] src;
    kind = $urandom_range(0, 9);
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
    doff = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
    src = ($urandom_range(0, 3) == 0) ? $urandom() : src_pool[$urandom_range(0, 15)];
    payload = {};
    if (kind <= 3) begin
      port = ($urandom_range(0, 3) != 0) ? cur_port : 16'($urandom_range(0, 65535));
      flags = $urandom_range(0, 1) ? 8'h18 : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) begin
        add_pat(PAT_GET, GET_LEN);
        payload.push_back(8'h20);
        add_pat($urandom_range(0, 1) ? PAT_HOST_A : PAT_HOST_B, HOST_LEN);
      end
      repeat ($urandom_range(1, 8)) add_piece();
      build_tcp(ihl, doff, port, flags, src);
    end else if (kind <= 5) begin
      flags = ($urandom_range(0, 3) != 0) ? {2'($urandom_range(0, 3)), FLAGS_SYN_ONLY}
                                          : 8'($urandom_range(0, 255));
      repeat ($urandom_range(0, 3)) add_piece();
      build_tcp(ihl, doff, 16'($urandom_range(0, 65535)), flags, src);
    end else if (kind <= 7) begin
      build_arp($urandom_range(0, 1) ? ARP_OP_REPLY : 16'($urandom_range(0, 3) << 8 * $urandom_range(0, 1)));
    end else if (kind == 8) begin
      frm = {};
      repeat ($urandom_range(1, 70)) frm.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 5)) add_piece();
      build_tcp(ihl, doff, cur_port, 8'($urandom_range(0, 255)), src);
      frm[23] = 8'($urandom_range(0, 255));
    end
    // truncated frames: fields past the end stay zero
    if ($urandom_range(0, 7) == 0) frm = frm[0:$urandom_range(0, frm.size() - 1)];
    send_frame();
  endtask

  task automatic directed_frames();
    frm = {8'hFF};                          send_frame();
    frm = {8'h00};                          send_frame();
    build_arp(ARP_OP_REPLY);                send_frame();
    build_arp(16'd1);                       send_frame();
    payload = {};
    build_tcp(5, 5, 16'd80, 8'h02, 32'h0A000001); send_frame();
    build_tcp(5, 5, 16'd80, 8'hC2, 32'h0A000001); send_frame();
    build_tcp(5, 5, 16'd443, 8'h02, 32'hFFFFFFFF); send_frame();
    build_tcp(5, 5, 16'd80, 8'h12, 32'h00000000); send_frame();
    payload = {}; add_pat(PAT_GET, 3); add_pat(PAT_HOST_A, 16);
    build_tcp(5, 5, 16'd80, 8'h18, 32'h01020304); send_frame();
    payload = {}; add_pat(PAT_GET, 3); add_pat(PAT_HOST_B, 16);
    build_tcp(5, 5, 16'd80, 8'h18, 32'h01020304); send_frame();
    payload = {}; add_pat(PAT_HOST_B, 16); add_pat(PAT_GET, 3); add_pat(PAT_HOST_A, 16);
    build_tcp(5, 5, 16'd80, 8'h18, 32'h01020304); send_frame();
    payload = {}; add_pat(PAT_HOST_A, 16);
    build_tcp(5, 5, 16'd80, 8'h18, 32'h01020304); send_frame();
    // zero byte ends the scan before the host string
    payload = {}; add_pat(PAT_GET, 3); payload.push_back(8'd0); add_pat(PAT_HOST_A, 16);
    build_tcp(5, 5, 16'd80, 8'h18, 32'h01020304); send_frame();
    payload = {}; add_pat(PAT_GET, 3); add_pat(PAT_HOST_A, 16);
    build_tcp(5, 5, 16'd81, 8'h18, 32'h01020304); send_frame();
    payload = {}; add_pat(PAT_GET, 3); add_pat(PAT_HOST_B, 16);
    build_tcp(5, 0, 16'd80, 8'h18, 32'h01020304); send_frame();
    payload = {}; add_pat(PAT_GET, 3); add_pat(PAT_HOST_A, 16);
    build_tcp(0, 5, 16'd80, 8'h02, 32'h05060708); send_frame();
    build_tcp(15, 15, 16'd80, 8'h18, 32'h05060708); send_frame();
    // overlapping prefixes: GGEGET and an extra run of w before the host
    payload = {}; add_pat(PAT_GET, 1); add_pat(PAT_GET, 2); add_pat(PAT_GET, 3);
    add_pat(PAT_HOST_A, 2); add_pat(PAT_HOST_A, 16);
    build_tcp(5, 5, 16'd80, 8'h18, 32'h01020304); send_frame();
    payload = {}; add_pat(PAT_GET, 3); add_pat(PAT_HOST_A, 16);
    build_tcp(5, 5, 16'd80, 8'h02, 32'h0A000002);
    frm = frm[0:39]; send_frame();
    build_tcp(5, 5, 16'd80, 8'h18, 32'h01020304);
    frm[23] = 8'd17; send_frame();
  endtask

  initial begin
    logic [15:0] ports[5];
    int phase_start;
    foreach (src_pool[i]) src_pool[i] = $urandom();
    ports = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 65534)), 16'd8080, 16'd80};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    directed_frames();
    foreach (ports[p]) begin
      wait_idle();
      write_port(ports[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 30) random_frame();
    end
    wait_idle();
    $display("covered %0d bytes in %0d frames over %0d port settings,", bytes_sent,
             frames_done, port_settings + 1);
    $display("including hold-off back-pressure, syn source tracking and host string hits");
    if (mismatches == 0 && outstanding == 0)
      $display("packet_threat_classifier_core regression: pass");
    else
      $display("packet_threat_classifier_core regression: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_queue.sv
hw/rtl/ptc_front.sv
hw/rtl/ptc_back.sv
hw/rtl/packet_threat_classifier_core.sv
sim/ptc_frame_checker.sv
sim/testbench.sv
